// ===== design/iambic_cw_keyer_envelope_defines.svh =====
// Assertion macros for the iambic CW keyer envelope block.
`ifndef IAMBIC_CW_KEYER_ENVELOPE_DEFINES_SVH
`define IAMBIC_CW_KEYER_ENVELOPE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define IKE_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define IKE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/ike_pkg.sv =====
// Shared types and constants of the iambic CW keyer envelope block.
`default_nettype none

package ike_pkg;

  localparam int COUNT_WIDTH = 20;
  localparam int AMP_WIDTH   = 16;

  localparam int ENV_WIDTH    = 16;
  localparam int AMP_IN_WIDTH = 16;
  localparam int DOT_WIDTH    = 16;
  localparam int RATIO_WIDTH  = 7;
  localparam int EDGE_WIDTH   = 12;
  localparam int FRAC_WIDTH   = 16;

  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 16;

  localparam int IN_TDATA_WIDTH  = 24;
  localparam int OUT_TDATA_WIDTH = 24;

  // input tdata bit positions
  localparam int IN_DOT_BIT    = 0;
  localparam int IN_DASH_BIT   = 1;
  localparam int IN_SERIAL_BIT = 2;
  localparam int IN_AMP_LSB    = 3;

  localparam logic [DOT_WIDTH-1:0]   DOT_RESET   = DOT_WIDTH'(2880);
  localparam logic [RATIO_WIDTH-1:0] RATIO_RESET = RATIO_WIDTH'(24);
  localparam logic [EDGE_WIDTH-1:0]  EDGE_RESET  = EDGE_WIDTH'(240);
  localparam logic [FRAC_WIDTH-1:0]  FRAC_RESET  = FRAC_WIDTH'(655);

  typedef enum logic [1:0] {
    EL_IDLE  = 2'd0,
    EL_DOT   = 2'd1,
    EL_DASH  = 2'd2,
    EL_SPACE = 2'd3
  } ike_element_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_KEYER_EN  = 3'd0,
    REG_IAMBIC_EN = 3'd1,
    REG_MODE_B    = 3'd2,
    REG_MEM_EN    = 3'd3,
    REG_DOT       = 3'd4,
    REG_RATIO     = 3'd5,
    REG_EDGE      = 3'd6,
    REG_FRAC      = 3'd7
  } ike_reg_e;

  typedef struct packed {
    logic                   keyer_en;
    logic                   iambic_en;
    logic                   mode_b;
    logic                   mem_en;
    logic [DOT_WIDTH-1:0]   dot_samples;
    logic [RATIO_WIDTH-1:0] dash_ratio;
    logic [EDGE_WIDTH-1:0]  edge_samples;
    logic [FRAC_WIDTH-1:0]  edge_frac;
  } ike_cfg_t;

  typedef struct packed {
    logic                 dot;
    logic                 dash;
    logic                 serial;
    logic [AMP_WIDTH-1:0] amp;
  } ike_item_t;

endpackage

`default_nettype wire

// ===== design/ike_keyer.sv =====
// Keyer sequencer: element state, sample counter, iambic flags, symbol memory.
`default_nettype none

module ike_keyer
  import ike_pkg::*;
(
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            fire_i,
  input  wire ike_cfg_t  cfg_i,
  input  wire ike_item_t item_i,
  output ike_element_e   element_o,
  output logic           rise_o
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] LEN_MAX = CNT_MAX - COUNT_WIDTH'(1);
  localparam int PROD_WIDTH = DOT_WIDTH + RATIO_WIDTH;

  ike_element_e           el_q, el_d, mem_q, mem_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   first_q, first_d, last_q, last_d, seq_q, seq_d;
  logic [1:0]             prev_q, prev_d;

  logic [PROD_WIDTH-1:0]  dash_prod;
  logic [PROD_WIDTH-4:0]  dash_raw;
  logic [COUNT_WIDTH-1:0] dot_len, dash_len;
  logic                   rise, done, both;

  assign dash_prod = PROD_WIDTH'(cfg_i.dot_samples) * PROD_WIDTH'(cfg_i.dash_ratio);
  assign dash_raw  = dash_prod[PROD_WIDTH-1:3];

  // lengths clamp one below the counter ceiling so every element ends
  assign dot_len  = (33'(cfg_i.dot_samples) > 33'(LEN_MAX)) ? LEN_MAX
                                                            : COUNT_WIDTH'(cfg_i.dot_samples);
  assign dash_len = (33'(dash_raw) > 33'(LEN_MAX)) ? LEN_MAX : COUNT_WIDTH'(dash_raw);

  // true inside the falling window at the tail of an element
  function automatic logic in_fall(input logic [COUNT_WIDTH-1:0] cnt,
                                   input logic [COUNT_WIDTH-1:0] len,
                                   input logic [EDGE_WIDTH-1:0]  edg);
    logic [COUNT_WIDTH-1:0] edg_w;
    logic [COUNT_WIDTH-1:0] start;
    edg_w = COUNT_WIDTH'(edg);
    start = (len > edg_w) ? len - edg_w : '0;
    return (cnt <= len) && (cnt > start);
  endfunction

  always_comb begin
    el_d    = el_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    last_d  = last_q;
    seq_d   = seq_q;
    mem_d   = mem_q;
    prev_d  = prev_q;
    rise    = 1'b0;
    done    = 1'b0;
    both    = item_i.dot && item_i.dash;

    if (!cfg_i.keyer_en) begin
      el_d = EL_IDLE;
      rise = item_i.serial || item_i.dot || item_i.dash;
    end else if (item_i.serial) begin
      rise = 1'b1;
    end else begin
      if (cnt_d != CNT_MAX) cnt_d = cnt_d + COUNT_WIDTH'(1);

      if (!seq_d) begin
        if (item_i.dot && !item_i.dash) first_d = 1'b0;
        if (!item_i.dot && item_i.dash) first_d = 1'b1;
        if (both) seq_d = 1'b1;
      end

      // one new press during an element is remembered
      if (cfg_i.mem_en && el_d != EL_IDLE) begin
        if (item_i.dot && !prev_q[0] && mem_d == EL_IDLE) mem_d = EL_DOT;
        if (item_i.dash && !prev_q[1] && mem_d == EL_IDLE) mem_d = EL_DASH;
      end
      prev_d = {item_i.dash, item_i.dot};

      if (el_d == EL_IDLE && item_i.dot) begin
        cnt_d = '0;
        el_d  = EL_DOT;
      end
      if (el_d == EL_DOT) begin
        if (cnt_d <= dot_len) begin
          rise = !in_fall(cnt_d, dot_len, cfg_i.edge_samples);
          done = 1'b1;
        end else begin
          last_d = 1'b0;
          cnt_d  = '0;
          el_d   = EL_SPACE;
        end
      end

      if (!done && el_d == EL_IDLE && item_i.dash) begin
        cnt_d = '0;
        el_d  = EL_DASH;
      end
      if (!done && el_d == EL_DASH) begin
        if (cnt_d <= dash_len) begin
          rise = !in_fall(cnt_d, dash_len, cfg_i.edge_samples);
          done = 1'b1;
        end else begin
          last_d = 1'b1;
          cnt_d  = '0;
          el_d   = EL_SPACE;
        end
      end

      if (!done && el_d == EL_SPACE) begin
        if (cnt_d <= dot_len) begin
          done = 1'b1;
        end else if (!cfg_i.iambic_en) begin
          if (cfg_i.mem_en && mem_d != EL_IDLE) begin
            cnt_d = '0;
            el_d  = mem_d;
            mem_d = EL_IDLE;
          end else begin
            el_d = EL_IDLE;
          end
        end else begin
          // mode A drops the sequence once both paddles are no longer held
          if (!cfg_i.mode_b && !both) begin
            el_d  = EL_IDLE;
            seq_d = 1'b0;
          end
          if (seq_d) begin
            cnt_d = '0;
            if (!last_d) begin
              el_d = EL_DASH;
              if (first_d && !both) begin
                seq_d = 1'b0;
                el_d  = EL_IDLE;
              end
            end else begin
              el_d = EL_DOT;
              if (!first_d && !both) begin
                seq_d = 1'b0;
                el_d  = EL_IDLE;
              end
            end
          end else begin
            el_d = EL_IDLE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      el_q    <= EL_IDLE;
      cnt_q   <= '0;
      first_q <= 1'b0;
      last_q  <= 1'b0;
      seq_q   <= 1'b0;
      mem_q   <= EL_IDLE;
      prev_q  <= 2'b00;
    end else if (fire_i) begin
      el_q    <= el_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
      last_q  <= last_d;
      seq_q   <= seq_d;
      mem_q   <= mem_d;
      prev_q  <= prev_d;
    end
  end

  assign element_o = el_q;
  assign rise_o    = rise;

endmodule

`default_nettype wire

// ===== design/ike_ramp.sv =====
// Envelope ramp: step by amplitude times fraction, clamped to zero and amplitude.
`default_nettype none

module ike_ramp
  import ike_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   fire_i,
  input  wire                   rise_i,
  input  wire  [AMP_WIDTH-1:0]  amp_i,
  input  wire  [FRAC_WIDTH-1:0] frac_i,
  output logic [AMP_WIDTH-1:0]  env_o
);

  localparam int PROD_WIDTH = AMP_WIDTH + FRAC_WIDTH;

  logic [AMP_WIDTH-1:0]  env_q, env_d;
  logic [PROD_WIDTH-1:0] prod;
  logic [AMP_WIDTH-1:0]  step;
  logic [AMP_WIDTH:0]    up_val;
  logic [AMP_WIDTH-1:0]  dn_val;

  assign prod = PROD_WIDTH'(amp_i) * PROD_WIDTH'(frac_i);
  assign step = prod[PROD_WIDTH-1:FRAC_WIDTH];

  always_comb begin
    up_val = (env_q < amp_i) ? ({1'b0, env_q} + {1'b0, step}) : {1'b0, env_q};
    dn_val = (env_q > step) ? env_q - step : '0;
    if (rise_i) begin
      env_d = (up_val > {1'b0, amp_i}) ? amp_i : up_val[AMP_WIDTH-1:0];
    end else begin
      env_d = (dn_val > amp_i) ? amp_i : dn_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= '0;
    end else if (fire_i) begin
      env_q <= env_d;
    end
  end

  assign env_o = env_q;

endmodule

`default_nettype wire

// ===== design/iambic_cw_keyer_envelope.sv =====
// Top level of the iambic CW keyer envelope: handshake, config registers, assertions.
//
// channel  | dir | handshake                     | payload
// ---------+-----+-------------------------------+------------------------------------
// s_axis   | in  | s_axis_tvalid / s_axis_tready | one audio sample: paddles, key, amp
// m_axis   | out | m_axis_tvalid / m_axis_tready | envelope level and keyer element
// cfg      | in  | cfg_we_i (no wait, no read)   | cfg_idx_i selects, cfg_data_i value
//
// One transaction per clock sustained while m_axis_tready stays high; an input is
// held in the input register and its result is valid once the state registers load.
// Longest path: dash-length multiply, keyer decision, then the ramp select.
// Reset clears the pipeline valids and keyer state and loads the register defaults.
// While the result waits, one more input transaction is still taken into the
// input register; after that s_axis_tready drops until m_axis_tready returns.
`default_nettype none
`include "iambic_cw_keyer_envelope_defines.svh"

module iambic_cw_keyer_envelope
  import ike_pkg::*;
(
  input  wire                          clk_i,
  input  wire                          rst_ni,

  input  wire                          cfg_we_i,
  input  wire  [CFG_IDX_WIDTH-1:0]     cfg_idx_i,
  input  wire  [CFG_DATA_WIDTH-1:0]    cfg_data_i,

  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // [0] dot_paddle, [1] dash_paddle, [2] serial_key, [18:3] amplitude, [23:19] zero
  input  wire  [IN_TDATA_WIDTH-1:0]    s_axis_tdata,

  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // [15:0] envelope, [17:16] element, [23:18] zero
  output logic [OUT_TDATA_WIDTH-1:0]   m_axis_tdata
);

  ike_cfg_t             cfg_q, cfg_d;
  ike_item_t            item_q, item_in;
  logic                 v1_q, v2_q;
  logic                 accept, fire;
  ike_element_e         element;
  logic                 rise;
  logic [AMP_WIDTH-1:0] env_lvl;
  logic [ENV_WIDTH-1:0] env_out;

  // ---- configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ike_reg_e'(cfg_idx_i))
        REG_KEYER_EN:  cfg_d.keyer_en     = cfg_data_i[0];
        REG_IAMBIC_EN: cfg_d.iambic_en    = cfg_data_i[0];
        REG_MODE_B:    cfg_d.mode_b       = cfg_data_i[0];
        REG_MEM_EN:    cfg_d.mem_en       = cfg_data_i[0];
        REG_DOT:       cfg_d.dot_samples  = cfg_data_i[DOT_WIDTH-1:0];
        REG_RATIO:     cfg_d.dash_ratio   = cfg_data_i[RATIO_WIDTH-1:0];
        REG_EDGE:      cfg_d.edge_samples = cfg_data_i[EDGE_WIDTH-1:0];
        REG_FRAC:      cfg_d.edge_frac    = cfg_data_i[FRAC_WIDTH-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.keyer_en     <= 1'b1;
      cfg_q.iambic_en    <= 1'b0;
      cfg_q.mode_b       <= 1'b0;
      cfg_q.mem_en       <= 1'b0;
      cfg_q.dot_samples  <= DOT_RESET;
      cfg_q.dash_ratio   <= RATIO_RESET;
      cfg_q.edge_samples <= EDGE_RESET;
      cfg_q.edge_frac    <= FRAC_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---- input register and result valid
  // fire: the held sample is processed and the state registers, which are the
  // result payload, take the new values
  assign fire          = v1_q && (!v2_q || m_axis_tready);
  assign s_axis_tready = !v1_q || !v2_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign item_in.dot    = s_axis_tdata[IN_DOT_BIT];
  assign item_in.dash   = s_axis_tdata[IN_DASH_BIT];
  assign item_in.serial = s_axis_tdata[IN_SERIAL_BIT];
  assign item_in.amp    = AMP_WIDTH'(s_axis_tdata[IN_AMP_LSB+AMP_IN_WIDTH-1:IN_AMP_LSB]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (accept)    v1_q <= 1'b1;
      else if (fire) v1_q <= 1'b0;
      if (fire)               v2_q <= 1'b1;
      else if (m_axis_tready) v2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_in;
  end

  // ---- keyer sequencer and envelope ramp
  ike_keyer u_keyer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .cfg_i     (cfg_q),
    .item_i    (item_q),
    .element_o (element),
    .rise_o    (rise)
  );

  ike_ramp u_ramp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .rise_i (rise),
    .amp_i  (item_q.amp),
    .frac_i (cfg_q.edge_frac),
    .env_o  (env_lvl)
  );

  assign env_out       = ENV_WIDTH'(env_lvl);
  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = OUT_TDATA_WIDTH'({element, env_out});

  // ---- assertions
  `IKE_ASSERT_NOW(a_fire_frees_input, fire, s_axis_tready, "input stalled while stage moves")
  `IKE_ASSERT_NEXT(a_fire_gives_result, fire, m_axis_tvalid, "processed sample gave no result")
  `IKE_ASSERT_NEXT(a_env_within_amp, fire, env_lvl <= $past(item_q.amp),
                   "envelope above its amplitude")
  `IKE_ASSERT_NEXT(a_serial_holds_element, fire && cfg_q.keyer_en && item_q.serial,
                   element == $past(element), "serial key moved the keyer state")

endmodule

`default_nettype wire
